// ===== src/svrp_pkg.sv =====
// ----------------------------------------------------------------------------
// svrp_pkg: shared types and constants
// Fixed field widths, Q0.16 constants, register indexes and penalty modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svrp_pkg;

  localparam int unsigned VarW    = 10;  // variable index width
  localparam int unsigned WeightW = 17;  // Q0.16 weight, 1.0 included
  localparam int unsigned SumW    = 22;  // Q6.16 running sum
  localparam int unsigned PenW    = 17;  // Q0.16 penalty
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 17;

  localparam int unsigned DefMaxDepth = 32;

  localparam logic [WeightW-1:0] OneQ16 = WeightW'(65536);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegPenaltyMode = 1'b0;
  localparam logic [CfgIdxW-1:0] RegWeight      = 1'b1;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_NEW  = 2'd1,
    MODE_EMA  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  // operand select for the shared multiplier
  typedef struct packed {
    logic en;       // capture a new product
    logic use_wt;   // 1: sum * w, 0: sum * (1 - w)
  } mul_ctrl_t;

endpackage

// ===== src/svrp_mul.sv =====
// ----------------------------------------------------------------------------
// svrp_mul: shared multiplier
// Multiplies the running sum by w or by (1 - w); product is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svrp_mul #(
  parameter int unsigned AW = svrp_pkg::SumW,
  parameter int unsigned BW = svrp_pkg::WeightW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  svrp_pkg::mul_ctrl_t  ctrl_i,
  input  logic [AW-1:0]        sum_i,
  input  logic [BW-1:0]        weight_i,   // already saturated to 1.0
  output logic [AW+BW-1:0]     prod_o
);

  logic [BW-1:0]    b_op;
  logic [AW+BW-1:0] prod_d, prod_q;

  assign b_op   = ctrl_i.use_wt ? weight_i : (svrp_pkg::OneQ16 - weight_i);
  assign prod_d = (AW+BW)'(sum_i) * (AW+BW)'(b_op);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (ctrl_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== src/split_variable_reuse_penalty.sv =====
// ----------------------------------------------------------------------------
// split_variable_reuse_penalty: split penalty for a candidate variable
// Streams the variables used along a branch and returns the reuse penalty
// of the candidate on the last transaction of each query.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit first)          | tuser      | tlast
//  s_axis   | in  | query_var[9:0], path_var[19:10] | path_empty | last
//  m_axis   | out | penalty[16:0]                  | -          | -
//  cfg      | in  | we / idx / data: 0 penalty_mode, 1 weight
//
//  States: a path entry passes ST_IDLE (accept) and ST_ACC (accumulate),
//  using the single shared multiplier. A last entry passes ST_IDLE, ST_ACC,
//  ST_FIN (final multiply) and ST_RES (result). An empty or over-depth
//  entry passes ST_IDLE only, plus ST_FIN and ST_RES when it is last.
//  Reset clears the sum, match flag, entry count and output register.
//  s_axis_tready is low while a transaction is being processed; a result
//  waits in the output register, and a query can run meanwhile, stalling
//  only at its own result until the previous one is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module split_variable_reuse_penalty #(
  parameter int unsigned PATH_DEPTH = svrp_pkg::DefMaxDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // query_var, path_var, pad
  input  logic                          s_axis_tuser,  // path_empty
  input  logic                          s_axis_tlast,  // last
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // penalty, pad
  // configuration
  input  logic                          cfg_we_i,
  input  logic [svrp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [svrp_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned CntW  = $clog2(PATH_DEPTH + 1);
  localparam int unsigned SumW  = svrp_pkg::SumW;
  localparam int unsigned WW    = svrp_pkg::WeightW;
  localparam int unsigned ProdW = SumW + WW;

  typedef enum logic [1:0] {
    ST_IDLE,   // wait for a transaction, launch the step multiply
    ST_ACC,    // fold product into the running sum
    ST_FIN,    // launch w * sum
    ST_RES     // form the penalty, hand it to the output register
  } state_e;

  // configuration registers
  svrp_pkg::mode_e mode_q;
  logic [WW-1:0]   weight_q;
  logic [WW-1:0]   w_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= svrp_pkg::MODE_NONE;
      weight_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        svrp_pkg::RegPenaltyMode: mode_q   <= svrp_pkg::mode_e'(cfg_data_i[1:0]);
        svrp_pkg::RegWeight:      weight_q <= cfg_data_i[WW-1:0];
        default: ;
      endcase
    end
  end

  // weight above 1.0 acts as 1.0
  assign w_eff = (weight_q > svrp_pkg::OneQ16) ? svrp_pkg::OneQ16 : weight_q;

  // input fields
  logic [svrp_pkg::VarW-1:0] query_var, path_var;
  assign query_var = s_axis_tdata[9:0];
  assign path_var  = s_axis_tdata[19:10];

  state_e               state_q, state_d;
  logic [SumW-1:0]      sum_q, sum_d;
  logic                 seen_q, seen_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 used_q, used_d;
  logic                 last_q, last_d;
  logic                 ovld_q, ovld_d;
  logic [svrp_pkg::PenW-1:0] open_q, open_d;

  logic                 in_acc, take, out_free;
  svrp_pkg::mul_ctrl_t  mul_ctrl;
  logic [ProdW-1:0]     prod;
  logic [ProdW-17:0]    prod_hi;      // product >> 16
  logic [SumW+1:0]      sum_ext;
  logic [svrp_pkg::PenW-1:0] pen;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign take     = !s_axis_tuser && (cnt_q < CntW'(PATH_DEPTH));
  assign out_free = !ovld_q || m_axis_tready;

  always_comb begin
    mul_ctrl.en     = (in_acc && take) || (state_q == ST_FIN);
    mul_ctrl.use_wt = (state_q == ST_FIN);
  end

  svrp_mul #(.AW(SumW), .BW(WW)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mul_ctrl),
    .sum_i    (sum_q),
    .weight_i (w_eff),
    .prod_o   (prod)
  );

  assign prod_hi = prod[ProdW-1:16];
  // floor(s*(1-w)) plus one for a fresh variable
  assign sum_ext = (SumW+2)'(prod_hi) + (used_q ? '0 : (SumW+2)'(svrp_pkg::OneQ16));

  always_comb begin
    pen = '0;
    if (cnt_q != '0) begin
      unique case (mode_q)
        svrp_pkg::MODE_NEW: pen = seen_q ? '0 : w_eff;
        svrp_pkg::MODE_EMA: pen = (prod_hi > (ProdW-16)'(svrp_pkg::OneQ16))
                                  ? svrp_pkg::OneQ16 : prod_hi[svrp_pkg::PenW-1:0];
        default:            pen = '0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    seen_d  = seen_q;
    cnt_d   = cnt_q;
    used_d  = used_q;
    last_d  = last_q;
    ovld_d  = ovld_q && !m_axis_tready;
    open_d  = open_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          used_d = (path_var == query_var);
          last_d = s_axis_tlast;
          if (take)              state_d = ST_ACC;
          else if (s_axis_tlast) state_d = ST_FIN;
        end
      end
      ST_ACC: begin
        sum_d   = sum_ext[SumW-1:0];
        seen_d  = seen_q || used_q;
        cnt_d   = cnt_q + CntW'(1);
        state_d = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: state_d = ST_RES;
      ST_RES: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          open_d  = pen;
          sum_d   = '0;
          seen_d  = 1'b0;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sum_q   <= '0;
      seen_q  <= 1'b0;
      cnt_q   <= '0;
      used_q  <= 1'b0;
      last_q  <= 1'b0;
      ovld_q  <= 1'b0;
      open_q  <= '0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      seen_q  <= seen_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      last_q  <= last_d;
      ovld_q  <= ovld_d;
      open_q  <= open_d;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {7'd0, open_q};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PATH_DEPTH))
    else $error("entry count past max depth");

  a_seen_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (cnt_q != '0))
    else $error("match flag set with no entries");

  a_pen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (open_q <= svrp_pkg::OneQ16))
    else $error("penalty above one");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RES && out_free) |=>
      (sum_q == '0 && cnt_q == '0 && !seen_q && state_q == ST_IDLE))
    else $error("query state not cleared after result");

endmodule

// ===== tb/split_variable_reuse_penalty_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_variable_reuse_penalty_tb: self-checking bench for the reuse penalty
// Streams queries of path entries into the block through a queue-fed driver,
// predicts each penalty in a bit-exact Q0.16/Q6.16 model and checks every
// result transaction in a monitor. The run steps through a series of
// register settings, each written while the block is idle, with random
// backpressure on both streams and two long output stalls.
// ----------------------------------------------------------------------------

module split_variable_reuse_penalty_tb;

  localparam int unsigned MaxDepth  = svrp_pkg::DefMaxDepth;
  localparam int          NumPhases = 12;
  localparam int          PhaseItems = 66;     // random items per setting
  localparam int          StallCycles = 400;   // long output hold-off
  localparam int          SettleCycles = 12;   // settle margin once the bench is idle

  // one input transaction
  typedef struct packed {
    logic [svrp_pkg::VarW-1:0] qv;      // candidate variable
    logic [svrp_pkg::VarW-1:0] pv;      // path variable
    logic                      empty;   // no path entry on this transaction
    logic                      last;    // closes the query
  } path_item_t;

  // --------------------------------------------------------------------------
  // DUT signals; everything the bench drives starts at a known value
  // --------------------------------------------------------------------------
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [23:0]                   s_axis_tdata = '0;   // query_var[9:0], path_var[19:10], pad
  logic                          s_axis_tuser = 1'b0; // path_empty
  logic                          s_axis_tlast = 1'b0; // last
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [23:0]                   m_axis_tdata;        // penalty[16:0], pad
  logic                          cfg_we_i = 1'b0;
  logic [svrp_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [svrp_pkg::CfgW-1:0]     cfg_data_i = '0;

  split_variable_reuse_penalty #(
    .PATH_DEPTH(MaxDepth)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  path_item_t                    pending_items[$];  // transactions not yet offered
  path_item_t                    held_item;         // transaction currently on s_axis
  logic [svrp_pkg::PenW-1:0]     penalty_q[$];      // penalties still to come out

  // idle odds in percent, updated per phase with NBAs
  int                  tx_idle_pct = 22;
  int                  rx_idle_pct = 61;

  // long stall request: main bumps press_req, monitor acknowledges
  int                  press_req = 0;
  int                  press_ack = 0;
  int                  hold_cnt = 0;

  int                  fail_cnt = 0;
  int                  items_in = 0;
  int                  queries_in = 0;
  int                  penalties_checked = 0;
  int                  entries_dropped = 0;

  // predictor copy of the block's registers and query state
  svrp_pkg::mode_e                 cur_mode = svrp_pkg::MODE_NONE;
  logic [svrp_pkg::WeightW-1:0]    cur_weight = '0;
  logic [svrp_pkg::SumW-1:0]       acc_sum = '0;      // Q6.16 Horner sum
  logic                            cand_seen = 1'b0;
  logic [5:0]                      depth_cnt = '0;

  // --------------------------------------------------------------------------
  // Penalty predictor: one call per accepted input transaction
  // --------------------------------------------------------------------------
  task automatic predict_penalty(input path_item_t it);
    longint unsigned w_eff;
    longint unsigned prod;
    longint unsigned pen;
    logic            hit;
    // weight saturates at 1.0
    w_eff = (cur_weight > svrp_pkg::OneQ16) ? 64'd65536 : 64'(cur_weight);
    if (!it.empty) begin
      if (depth_cnt < MaxDepth) begin
        hit  = (it.pv == it.qv);  // compared against this transaction's candidate
        prod = (64'(acc_sum) * (64'd65536 - w_eff)) >> 16;
        if (!hit) prod = prod + 64'd65536;
        acc_sum   = prod[svrp_pkg::SumW-1:0];
        cand_seen = cand_seen | hit;
        depth_cnt = depth_cnt + 6'd1;
      end else begin
        entries_dropped++;  // past the depth limit, no effect
      end
    end
    if (it.last) begin
      pen = 0;
      // root query (nothing taken) stays 0; modes 0 and 3 give 0
      if (depth_cnt != 0) begin
        if (cur_mode == svrp_pkg::MODE_NEW) begin
          pen = cand_seen ? 64'd0 : w_eff;
        end else if (cur_mode == svrp_pkg::MODE_EMA) begin
          pen = (w_eff * 64'(acc_sum)) >> 16;
          if (pen > 64'd65536) pen = 64'd65536;
        end
      end
      penalty_q.push_back(pen[svrp_pkg::PenW-1:0]);
      queries_in++;
      acc_sum   = '0;
      cand_seen = 1'b0;
      depth_cnt = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers pending transactions, holds each until accepted
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_penalty(held_item);
        items_in++;
      end
      // valid only drops after a transaction completes, never while held
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          held_item     = pending_items.pop_front();
          s_axis_tdata  <= {4'b0, held_item.pv, held_item.qv};
          s_axis_tuser  <= held_item.empty;
          s_axis_tlast  <= held_item.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks results in order and throttles m_axis_tready
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : mon
    logic [svrp_pkg::PenW-1:0] want_pen;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
      press_ack     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (penalty_q.size() == 0) begin
          $error("penalty: no result expected, actual %0d",
                 m_axis_tdata[svrp_pkg::PenW-1:0]);
          fail_cnt++;
        end else begin
          want_pen = penalty_q.pop_front();
          if (m_axis_tdata[svrp_pkg::PenW-1:0] !== want_pen) begin
            $error("penalty mismatch: expected %0d, actual %0d",
                   want_pen, m_axis_tdata[svrp_pkg::PenW-1:0]);
            fail_cnt++;
          end
          penalties_checked++;
        end
      end
      // a long hold-off lets the output register fill and back up s_axis
      if (press_req != press_ack) begin
        press_ack     <= press_req;
        hold_cnt      <= StallCycles;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt      <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_item(input logic [svrp_pkg::VarW-1:0] qv,
                          input logic [svrp_pkg::VarW-1:0] pv,
                          input logic empty, input logic last);
    path_item_t it;
    it.qv = qv;
    it.pv = pv;
    it.empty = empty;
    it.last = last;
    pending_items.push_back(it);
  endtask

  // register write; the predictor follows at the same time since the
  // block is idle and nothing is in flight
  task automatic write_cfg(input logic [svrp_pkg::CfgIdxW-1:0] idx,
                           input logic [svrp_pkg::CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == svrp_pkg::RegPenaltyMode) cur_mode = svrp_pkg::mode_e'(data[1:0]);
    else cur_weight = data[svrp_pkg::WeightW-1:0];
  endtask

  // wait until nothing is queued, offered or owed, then let the pipe settle
  task automatic wait_idle();
    while (pending_items.size() != 0 || s_axis_tvalid || penalty_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one random query; returns the number of transactions that count
  task automatic add_random_query(output int n);
    int                        kind;
    int                        len;
    logic [svrp_pkg::VarW-1:0] qv;
    logic [svrp_pkg::VarW-1:0] pv;
    logic                      empty;
    kind = $urandom_range(99);
    qv   = svrp_pkg::VarW'($urandom);
    n    = 0;
    if (kind < 5) begin
      // root query: a lone empty marker that ends the query
      add_item(qv, svrp_pkg::VarW'($urandom), 1'b1, 1'b1);
      n = 1;
    end else if (kind < 10) begin
      // noise: empty marker that does not end anything
      add_item(qv, svrp_pkg::VarW'($urandom), 1'b1, 1'b0);
    end else begin
      len = (kind < 18) ? $urandom_range(MaxDepth + 8, MaxDepth + 1)
                        : $urandom_range(6, 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 4) qv = svrp_pkg::VarW'($urandom);  // candidate changes
        pv    = ($urandom_range(99) < 25) ? qv : svrp_pkg::VarW'($urandom);
        empty = ($urandom_range(99) < 8);
        add_item(qv, pv, empty, i == len - 1);
      end
      n = len;
    end
  endtask

  // register setting per phase: extremes first, random ones later
  task automatic phase_setting(input int ph, output svrp_pkg::mode_e m,
                               output logic [svrp_pkg::WeightW-1:0] w);
    case (ph)
      0:  begin m = svrp_pkg::MODE_NEW;  w = 17'd65536; end
      1:  begin m = svrp_pkg::MODE_NEW;  w = 17'h1FFFF; end  // above 1.0, saturates
      2:  begin m = svrp_pkg::MODE_EMA;  w = 17'd65536; end
      3:  begin m = svrp_pkg::MODE_RSVD; w = 17'd40000; end
      4:  begin m = svrp_pkg::MODE_EMA;  w = 17'd0;     end
      5:  begin m = svrp_pkg::MODE_NONE; w = svrp_pkg::WeightW'($urandom); end
      6:  begin m = svrp_pkg::MODE_EMA;  w = 17'd1;     end
      7:  begin
        m = svrp_pkg::MODE_NEW;
        w = svrp_pkg::WeightW'($urandom_range(65536, 0));
      end
      8:  begin
        m = svrp_pkg::MODE_EMA;
        w = svrp_pkg::WeightW'($urandom_range(65536, 0));
      end
      9:  begin m = svrp_pkg::MODE_EMA;  w = 17'd32768; end
      10: begin m = svrp_pkg::MODE_EMA;  w = svrp_pkg::WeightW'($urandom); end
      default: begin m = svrp_pkg::MODE_NEW; w = 17'd0; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    svrp_pkg::mode_e              ph_mode;
    logic [svrp_pkg::WeightW-1:0] ph_weight;
    int                           added;
    int                           n;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();

      // sender 22 / receiver 61, then swapped, then no idling
      if (ph < 4) begin
        tx_idle_pct <= 22;
        rx_idle_pct <= 61;
      end else if (ph < 8) begin
        tx_idle_pct <= 61;
        rx_idle_pct <= 22;
      end else begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end

      phase_setting(ph, ph_mode, ph_weight);
      // mode write carries junk in the unused upper bits
      write_cfg(svrp_pkg::RegPenaltyMode, {(svrp_pkg::CfgW-2)'($urandom), 2'(ph_mode)});
      write_cfg(svrp_pkg::RegWeight, ph_weight);

      // directed cases
      case (ph)
        0: begin
          add_item(10'd5, 10'd0, 1'b1, 1'b1);        // root query
          add_item(10'd0, 10'd0, 1'b0, 1'b1);        // candidate reused
          add_item(10'd1023, 10'd0, 1'b0, 1'b1);     // new variable
          add_item(10'd1023, 10'd1023, 1'b0, 1'b0);  // reuse early in path
          add_item(10'd1023, 10'd17, 1'b0, 1'b1);
          add_item(10'd3, 10'd9, 1'b0, 1'b0);        // candidate changes mid query
          add_item(10'd9, 10'd9, 1'b0, 1'b1);
          add_item(10'd4, 10'd4, 1'b1, 1'b0);        // empty marker ignores match
          add_item(10'd4, 10'd8, 1'b0, 1'b1);
        end
        1: begin
          add_item(10'd0, 10'd1023, 1'b0, 1'b1);     // weight above 1.0
        end
        2: begin
          add_item(10'd2, 10'd3, 1'b0, 1'b0);
          add_item(10'd2, 10'd2, 1'b0, 1'b0);
          add_item(10'd2, 10'd0, 1'b1, 1'b1);        // empty marker ends query
          add_item(10'd7, 10'd7, 1'b1, 1'b1);        // root query in EMA mode
        end
        3: begin
          add_item(10'd1, 10'd2, 1'b0, 1'b1);        // unused mode gives 0
          add_item(10'd6, 10'd6, 1'b0, 1'b1);
        end
        default: ;
      endcase

      added = 0;
      while (added < PhaseItems) begin
        add_random_query(n);
        added += n;
      end

      // long output stall while the sender keeps pushing
      if (ph == 2 || ph == 9) press_req <= press_req + 1;
    end

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (penalty_q.size() != 0) begin
      $error("penalty: %0d expected results never arrived", penalty_q.size());
      fail_cnt++;
    end

    $display("Summary: %0d input transactions, %0d queries, %0d penalties checked",
             items_in, queries_in, penalties_checked);
    $display("  %0d register settings over all modes, %0d entries past depth dropped",
             NumPhases, entries_dropped);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
